FILE: rtl/csf_pkg.sv
// Package: shared constants and types for the carrier-smoothed code filter.
`default_nettype none

package csf_pkg;

   localparam int NUM_SATS_DEF   = 64;
   localparam int MEAS_WIDTH_DEF = 48;

   localparam int SAT_W  = 6;
   localparam int WIN_W  = 11;
   localparam int CALC_W = 64;

   localparam logic [WIN_W-1:0] WIN_LIMIT = 11'd1024;
   localparam logic [WIN_W-1:0] WIN_RESET = 11'd100;
   localparam logic [WIN_W-1:0] WIN_ONE   = 11'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_FIX,
      ST_DONE
   } csf_state_type;

endpackage

`default_nettype wire

FILE: rtl/csf_if.sv
// Interfaces: request and response channels of the carrier-smoothed code filter.
`default_nettype none

interface csf_req_if #(
   parameter int MEAS_WIDTH = csf_pkg::MEAS_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [csf_pkg::SAT_W-1:0]     sat_index;
   logic signed [MEAS_WIDTH-1:0]  code_meas;
   logic signed [MEAS_WIDTH-1:0]  phase_meas;
   logic                          slip_flag;

   modport source (output valid, sat_index, code_meas, phase_meas, slip_flag, input ready);
   modport sink   (input valid, sat_index, code_meas, phase_meas, slip_flag, output ready);
endinterface

interface csf_rsp_if #(
   parameter int MEAS_WIDTH = csf_pkg::MEAS_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic signed [MEAS_WIDTH-1:0]  smoothed_code;
   logic [csf_pkg::WIN_W-1:0]     window_used;

   modport source (output valid, accepted, smoothed_code, window_used, input ready);
   modport sink   (input valid, accepted, smoothed_code, window_used, output ready);
endinterface

`default_nettype wire

FILE: rtl/csf_div.sv
// Divider: iterative unsigned restoring division by the window, two quotient bits per cycle.
`default_nettype none

module csf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [csf_pkg::CALC_W-1:0]   dividend,
   input  logic [csf_pkg::WIN_W-1:0]    divisor,
   output logic                         done,
   output logic [csf_pkg::CALC_W-1:0]   quotient
);
   import csf_pkg::*;

   localparam int STEPS = CALC_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CALC_W-1:0] quo_ff, quo_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [WIN_W-1:0]  div_ff, div_in;

   logic [WIN_W:0]    t0, t1;
   logic              ge0, ge1;
   logic [WIN_W-1:0]  r0, r1;
   logic [CALC_W-1:0] q0, q1;

   always_comb begin
      t0  = {rem_ff, quo_ff[CALC_W-1]};
      ge0 = (t0 >= {1'b0, div_ff});
      r0  = ge0 ? WIN_W'(t0 - {1'b0, div_ff}) : WIN_W'(t0);
      q0  = {quo_ff[CALC_W-2:0], ge0};
      t1  = {r0, q0[CALC_W-1]};
      ge1 = (t1 >= {1'b0, div_ff});
      r1  = ge1 ? WIN_W'(t1 - {1'b0, div_ff}) : WIN_W'(t1);
      q1  = {q0[CALC_W-2:0], ge1};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = q1;
         rem_in = r1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/carrier_smoothed_code_filter_unit.sv
// Top level: per-satellite carrier-smoothed code filter with state in one table memory.
//
//   channel   direction   beat contents
//   req_bus   in          sat_index, code_meas, phase_meas, slip_flag
//   rsp_bus   out         accepted, smoothed_code, window_used
//   csr_*     in          max_window write, no read-back
//
// A smoothed sample passes table read, difference, multiply, divider load, 32 two-bit divider
// steps, done flag, sign fix and output load on its way to the output register.
// A rejected sample goes from accept straight to ST_DONE and the output load.
// One sample is in work at a time; the next is taken once the result is loaded into the output
// register, which holds while rsp_bus.ready is low and then makes the next load wait.
// Reset is synchronous; the table comes up empty through per-entry valid bits.
`default_nettype none

module carrier_smoothed_code_filter_unit #(
   parameter int NUM_SATS   = csf_pkg::NUM_SATS_DEF,
   parameter int MEAS_WIDTH = csf_pkg::MEAS_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   csf_req_if.sink                    req_bus,
   csf_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [csf_pkg::WIN_W-1:0]  csr_wr_data
);
   import csf_pkg::*;

   localparam int IDX_W = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
   localparam int ENT_W = 2 * MEAS_WIDTH + WIN_W;
   localparam logic signed [CALC_W-1:0] MEAS_MAX =
      {{(CALC_W - MEAS_WIDTH + 1){1'b0}}, {(MEAS_WIDTH - 1){1'b1}}};
   localparam logic signed [CALC_W-1:0] MEAS_MIN = ~MEAS_MAX;

   csf_state_type state_ff, state_in;

   logic [WIN_W-1:0]              max_win_ff;
   logic [IDX_W-1:0]              addr_ff;
   logic signed [MEAS_WIDTH-1:0]  code_ff, phase_ff;
   logic                          slip_ff, reject_ff;
   logic [ENT_W-1:0]              rd_ent_ff;
   logic                          rd_vld_ff;
   logic [NUM_SATS-1:0]           vld_ff;
   logic [WIN_W-1:0]              n_ff;
   logic [CALC_W-1:0]             d_ff, total_ff;
   logic                          neg_ff;
   logic signed [MEAS_WIDTH-1:0]  res_ff;
   logic                          rsp_valid_ff, rsp_acc_ff;
   logic signed [MEAS_WIDTH-1:0]  rsp_code_ff;
   logic [WIN_W-1:0]              rsp_win_ff;

   logic [ENT_W-1:0] mem [NUM_SATS];

   logic                          accept, good, out_load, div_start, div_done;
   logic [IDX_W-1:0]              rd_addr;
   logic [WIN_W-1:0]              prev_win, n_calc;
   logic [WIN_W:0]                n_inc;
   logic signed [MEAS_WIDTH-1:0]  ls_raw, lp_raw;
   logic signed [CALC_W-1:0]      ls_ext, lp_ext, ph_ext, code_ext, q_signed;
   logic [WIN_W-2:0]              nm1;
   logic [CALC_W-1:0]             prod, div_dividend, div_quo;

   assign rd_addr       = IDX_W'(req_bus.sat_index);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign good          = (10'(req_bus.sat_index) < 10'(NUM_SATS)) &&
                          (req_bus.code_meas != '0) && (req_bus.phase_meas != '0);

   always_comb begin
      state_in  = state_ff;
      out_load  = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = good ? ST_LOAD : ST_DONE;
            end
         end
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_START;
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:   state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_win_ff <= WIN_RESET;
      end else if (csr_wr_en) begin
         priority if (csr_wr_data == '0) begin
            max_win_ff <= WIN_ONE;
         end else if (csr_wr_data > WIN_LIMIT) begin
            max_win_ff <= WIN_LIMIT;
         end else begin
            max_win_ff <= csr_wr_data;
         end
      end
   end

   // table read and write-back
   always_ff @(posedge clock) begin
      rd_ent_ff <= mem[rd_addr];
      if (out_load && !reject_ff) begin
         mem[addr_ff] <= {res_ff, phase_ff, n_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (out_load && !reject_ff) begin
            vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      ls_raw   = rd_ent_ff[ENT_W-1 -: MEAS_WIDTH];
      lp_raw   = rd_ent_ff[WIN_W +: MEAS_WIDTH];
      prev_win = rd_vld_ff ? rd_ent_ff[WIN_W-1:0] : '0;
      ls_ext   = rd_vld_ff ? CALC_W'(ls_raw) : '0;
      lp_ext   = rd_vld_ff ? CALC_W'(lp_raw) : '0;
      ph_ext   = CALC_W'(phase_ff);
      code_ext = CALC_W'(code_ff);
      n_inc    = {1'b0, prev_win} + 1'b1;
      priority if (slip_ff) begin
         n_calc = WIN_ONE;
      end else if (n_inc > {1'b0, max_win_ff}) begin
         n_calc = max_win_ff;
      end else begin
         n_calc = WIN_W'(n_inc);
      end
      nm1          = (WIN_W-1)'(n_ff - 1'b1);
      prod         = d_ff * nm1;
      div_dividend = total_ff[CALC_W-1] ? (~total_ff + 1'b1) : total_ff;
      q_signed     = neg_ff ? signed'(~div_quo + 1'b1) : signed'(div_quo);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= rd_addr;
         code_ff   <= req_bus.code_meas;
         phase_ff  <= req_bus.phase_meas;
         slip_ff   <= req_bus.slip_flag;
         reject_ff <= !good;
      end
      if (state_ff == ST_LOAD) begin
         n_ff <= n_calc;
         d_ff <= ls_ext + ph_ext - lp_ext;
      end
      if (state_ff == ST_MUL) begin
         total_ff <= code_ext + prod;
      end
      if (div_start) begin
         neg_ff <= total_ff[CALC_W-1];
      end
      if (state_ff == ST_FIX) begin
         priority if (q_signed > MEAS_MAX) begin
            res_ff <= MEAS_WIDTH'(MEAS_MAX);
         end else if (q_signed < MEAS_MIN) begin
            res_ff <= MEAS_WIDTH'(MEAS_MIN);
         end else begin
            res_ff <= MEAS_WIDTH'(q_signed);
         end
      end
   end

   csf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // output register: load when empty or drained this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_acc_ff  <= !reject_ff;
         rsp_code_ff <= reject_ff ? '0 : res_ff;
         rsp_win_ff  <= reject_ff ? '0 : n_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.accepted      = rsp_acc_ff;
   assign rsp_bus.smoothed_code = rsp_code_ff;
   assign rsp_bus.window_used   = rsp_win_ff;

endmodule

`default_nettype wire

FILE: dv/tb_carrier_smoothed_code_filter_unit.sv
// Testbench for the carrier-smoothed code filter: directed and random samples checked beat by beat.
`timescale 1ns / 1ps

module tb_carrier_smoothed_code_filter_unit;
   import csf_pkg::*;

   localparam int MEAS_W = MEAS_WIDTH_DEF;
   localparam longint MEAS_MAX = (longint'(1) <<< (MEAS_W - 1)) - 1;
   localparam longint MEAS_MIN = -MEAS_MAX - 1;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int DRAIN_CYCLES = 50;

   typedef struct {
      logic [SAT_W-1:0] sat;
      longint           code;
      longint           phase;
      bit               slip;
   } sample_type;

   typedef struct {
      bit     accepted;
      longint smoothed;
      int     window;
   } result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [WIN_W-1:0] csr_wr_data;

   csf_req_if #(.MEAS_WIDTH(MEAS_W)) req_bus ();
   csf_rsp_if #(.MEAS_WIDTH(MEAS_W)) rsp_bus ();

   carrier_smoothed_code_filter_unit #(
      .NUM_SATS   (NUM_SATS_DEF),
      .MEAS_WIDTH (MEAS_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // filter state as predicted
   longint smooth_mem [NUM_SATS_DEF];
   longint phase_mem [NUM_SATS_DEF];
   int win_mem [NUM_SATS_DEF];
   int max_win;

   // track generator state
   bit trk_live [NUM_SATS_DEF];
   longint trk_range [NUM_SATS_DEF];
   longint trk_amb [NUM_SATS_DEF];
   longint trk_rate [NUM_SATS_DEF];

   result_type smoothed_due [$];
   result_type due;
   int mismatches = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int cycle_count;

   function automatic longint to_meas(input longint x);
      logic signed [MEAS_W-1:0] v;
      v = x[MEAS_W-1:0];
      return longint'(v);
   endfunction

   function automatic longint rand_meas();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return to_meas(longint'(raw));
   endfunction

   function automatic result_type smooth_sample(input sample_type s);
      result_type r;
      int win_n;
      longint drift, total, quot;
      r.accepted = 1'b0;
      r.smoothed = 0;
      r.window = 0;
      if (s.code == 0 || s.phase == 0) return r;
      if (s.slip) begin
         win_n = 1;
         quot = s.code;
      end else begin
         win_n = win_mem[s.sat] + 1;
         if (win_n > max_win) win_n = max_win;
         drift = smooth_mem[s.sat] + s.phase - phase_mem[s.sat];
         total = s.code + longint'(win_n - 1) * drift;
         quot = total / longint'(win_n);
         if (quot > MEAS_MAX) quot = MEAS_MAX;
         else if (quot < MEAS_MIN) quot = MEAS_MIN;
      end
      smooth_mem[s.sat] = quot;
      phase_mem[s.sat] = s.phase;
      win_mem[s.sat] = win_n;
      r.accepted = 1'b1;
      r.smoothed = quot;
      r.window = win_n;
      return r;
   endfunction

   function automatic sample_type next_track_sample();
      sample_type s;
      int roll;
      int sat;
      roll = $urandom_range(99);
      s.slip = 1'b0;
      if (roll < 8) begin
         s.sat = SAT_W'($urandom_range(63));
         s.code = rand_meas();
         s.phase = rand_meas();
         s.slip = bit'($urandom_range(1));
      end else if (roll < 11) begin
         s.sat = SAT_W'($urandom_range(63));
         s.code = ($urandom_range(1) == 1) ? MEAS_MAX : MEAS_MIN;
         s.phase = ($urandom_range(1) == 1) ? MEAS_MAX : MEAS_MIN;
         s.slip = bit'($urandom_range(1));
      end else begin
         sat = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(7);
         if (!trk_live[sat] || $urandom_range(39) == 0) begin
            trk_live[sat] = 1'b1;
            trk_range[sat] = longint'(20_000_000) * 1024 + (longint'($urandom) <<< 2);
            trk_amb[sat] = rand_meas() >>> 8;
            trk_rate[sat] = longint'($urandom_range(1_600_000)) - 800_000;
            s.slip = 1'b1;
         end
         trk_range[sat] += trk_rate[sat];
         s.sat = SAT_W'(sat);
         s.code = trk_range[sat] + longint'($urandom_range(8191)) - 4096;
         s.phase = trk_range[sat] + trk_amb[sat] + longint'($urandom_range(15)) - 8;
         // drop one measurement now and then
         if (roll < 15) begin
            if ($urandom_range(1) == 1) s.code = 0;
            else s.phase = 0;
         end
      end
      return s;
   endfunction

   task automatic send_sample(input int sat, input longint code, input longint phase,
                              input bit slip);
      sample_type s;
      s.sat = SAT_W'(sat);
      s.code = to_meas(code);
      s.phase = to_meas(phase);
      s.slip = slip;
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sat_index <= s.sat;
      req_bus.code_meas <= s.code[MEAS_W-1:0];
      req_bus.phase_meas <= s.phase[MEAS_W-1:0];
      req_bus.slip_flag <= s.slip;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      smoothed_due.push_back(smooth_sample(s));
      @(negedge clock);
   endtask

   task automatic send_track_sample();
      sample_type s;
      s = next_track_sample();
      send_sample(s.sat, s.code, s.phase, s.slip);
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (smoothed_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_window(input int value);
      logic [WIN_W-1:0] v;
      v = WIN_W'(value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (v == 0) max_win = 1;
      else if (v > WIN_LIMIT) max_win = int'(WIN_LIMIT);
      else max_win = int'(v);
   endtask

   task automatic set_pacing(input int gap_pct, input int stall_pct);
      @(posedge clock);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      @(negedge clock);
   endtask

   task automatic test_rejects();
      send_sample(5, 0, 777, 1'b0);
      send_sample(5, 888, 0, 1'b1);
      send_sample(5, 0, 0, 1'b0);
      send_sample(5, 1000, 2000, 1'b0);
   endtask

   task automatic test_slip_pass_through();
      send_sample(0, MEAS_MAX, MEAS_MIN, 1'b1);
      send_sample(63, MEAS_MIN, MEAS_MAX, 1'b1);
   endtask

   task automatic test_window_growth();
      send_sample(7, 123456, -98765, 1'b0);
      send_sample(1, -5_000_000, 3_000_000, 1'b1);
      send_sample(1, -5_000_900, 3_000_411, 1'b0);
      send_sample(1, -5_001_733, 3_000_877, 1'b0);
      send_sample(1, -5_002_101, 3_001_350, 1'b0);
   endtask

   task automatic test_saturation();
      send_sample(2, MEAS_MAX, -(longint'(1) <<< 46), 1'b1);
      send_sample(2, MEAS_MAX, longint'(1) <<< 46, 1'b0);
      send_sample(3, MEAS_MIN, longint'(1) <<< 46, 1'b1);
      send_sample(3, MEAS_MIN, -(longint'(1) <<< 46), 1'b0);
   endtask

   task automatic test_window_register();
      wait_results_drained();
      write_max_window(0);
      send_sample(1, -5_002_600, 3_001_800, 1'b0);
      wait_results_drained();
      write_max_window(2047);
      send_sample(1, -5_003_050, 3_002_290, 1'b0);
      wait_results_drained();
      write_max_window(1);
      send_sample(1, -5_003_500, 3_002_700, 1'b0);
      wait_results_drained();
      write_max_window(1024);
      send_sample(1, -5_003_980, 3_003_120, 1'b0);
   endtask

   task automatic test_shrunk_window();
      int k;
      wait_results_drained();
      write_max_window(100);
      send_sample(4, 21_000_000_000, -7_000_000_000, 1'b1);
      for (k = 1; k <= 5; k++)
         send_sample(4, 21_000_000_000 + k * 700 + $urandom_range(63),
                     -7_000_000_000 + k * 700, 1'b0);
      wait_results_drained();
      write_max_window(3);
      send_sample(4, 21_000_004_250, -6_999_995_800, 1'b0);
   endtask

   task automatic test_backpressure();
      int k;
      wait_results_drained();
      write_max_window(64);
      set_pacing(0, 0);
      // hold the response side while the sender keeps offering beats
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      for (k = 0; k < 12; k++) send_track_sample();
      wait_results_drained();
   endtask

   task automatic test_random_tracks(input int count, input int window,
                                     input int gap_pct, input int stall_pct);
      int k;
      wait_results_drained();
      write_max_window(window);
      set_pacing(gap_pct, stall_pct);
      for (k = 0; k < count; k++) send_track_sample();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (smoothed_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: accepted %0b smoothed %0d window %0d",
                        rsp_bus.accepted, rsp_bus.smoothed_code, rsp_bus.window_used);
         end else begin
            due = smoothed_due.pop_front();
            if (rsp_bus.accepted !== due.accepted ||
                rsp_bus.smoothed_code !== due.smoothed[MEAS_W-1:0] ||
                rsp_bus.window_used !== WIN_W'(due.window)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                           due.accepted, due.smoothed, due.window, rsp_bus.accepted,
                           rsp_bus.smoothed_code, rsp_bus.window_used);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int i;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.sat_index = '0;
      req_bus.code_meas = '0;
      req_bus.phase_meas = '0;
      req_bus.slip_flag = 1'b0;
      rsp_bus.ready = 1'b0;
      for (i = 0; i < NUM_SATS_DEF; i++) begin
         smooth_mem[i] = 0;
         phase_mem[i] = 0;
         win_mem[i] = 0;
         trk_live[i] = 1'b0;
      end
      max_win = int'(WIN_RESET);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_rejects();
      test_slip_pass_through();
      test_window_growth();
      test_saturation();
      test_window_register();
      test_shrunk_window();
      test_backpressure();
      test_random_tracks(340, 16, 23, 63);
      test_random_tracks(340, 1024, 63, 23);
      test_random_tracks(340, $urandom_range(2, 300), 0, 0);
      wait_results_drained();

      if (mismatches == 0 && smoothed_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
